[sv/totp_pkg.sv]
// ----------------------------------------------------------------------------
// totp_pkg
// Shared types, SHA-256 constants and helper functions for the TOTP block.
// ----------------------------------------------------------------------------
package totp_pkg;

  localparam int TIME_W  = 63;
  localparam int CODE_W  = 30;
  localparam int LEFT_W  = 16;
  localparam int CFG_W   = 64;
  localparam int CFG_IDX_W = 3;
  localparam int CNT_W   = 6;

  // Iteration counts of the sequential units
  localparam logic [CNT_W-1:0] DIV_LAST = 6'd62;  // 63 quotient bits
  localparam logic [CNT_W-1:0] RND_LAST = 6'd63;  // 64 rounds
  localparam logic [CNT_W-1:0] MOD_LAST = 6'd30;  // 31 dividend bits

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY3   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KLEN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DIGITS = 3'd6;

  // Block selection for the four compressions
  localparam logic [1:0] BLK_IPAD  = 2'd0;
  localparam logic [1:0] BLK_MSG   = 2'd1;
  localparam logic [1:0] BLK_OPAD  = 2'd2;
  localparam logic [1:0] BLK_INNER = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV, ST_HLOAD, ST_ROUND, ST_HADD, ST_TRUNC, ST_MOD, ST_FINISH
  } state_t;

  typedef struct packed {
    logic             load_in;
    logic             div_step;
    logic             blk_load;
    logic [1:0]       blk_sel;
    logic             round;
    logic [CNT_W-1:0] rnd_idx;
    logic             hadd;
    logic             trunc_load;
    logic             mod_step;
    logic             out_load;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic out_full;
  } status_t;

  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
    32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
    32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
    32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
    32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
    32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
    32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
    32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
    32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
    32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
    32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2
  };

  localparam logic [31:0] SHA_IV [8] = '{
    32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
    32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    logic [63:0] d;
    d = {x, x} >> n;
    return d[31:0];
  endfunction

  // 10^d for d = 0..9
  function automatic logic [CODE_W-1:0] pow10(input logic [3:0] d);
    logic [CODE_W-1:0] p;
    case (d)
      4'd0:    p = 30'd1;
      4'd1:    p = 30'd10;
      4'd2:    p = 30'd100;
      4'd3:    p = 30'd1000;
      4'd4:    p = 30'd10000;
      4'd5:    p = 30'd100000;
      4'd6:    p = 30'd1000000;
      4'd7:    p = 30'd10000000;
      4'd8:    p = 30'd100000000;
      default: p = 30'd1000000000;
    endcase
    return p;
  endfunction

endpackage

[sv/totp_if.sv]
// ----------------------------------------------------------------------------
// totp_in_if / totp_out_if
// Valid/ready channels for time input and code results.
// ----------------------------------------------------------------------------
interface totp_in_if;
  logic                       valid;
  logic                       ready;
  logic [totp_pkg::TIME_W-1:0] time_seconds;

  modport source (output valid, output time_seconds, input ready);
  modport sink   (input valid, input time_seconds, output ready);
endinterface

interface totp_out_if;
  logic                        valid;
  logic                        ready;
  logic [totp_pkg::CODE_W-1:0] code;
  logic [totp_pkg::LEFT_W-1:0] seconds_left;
  logic                        code_valid;
  logic                        secret_long_enough;

  modport source (output valid, output code, output seconds_left, output code_valid,
                  output secret_long_enough, input ready);
  modport sink   (input valid, input code, input seconds_left, input code_valid,
                  input secret_long_enough, output ready);
endinterface

[sv/totp_ctrl.sv]
// ----------------------------------------------------------------------------
// totp_ctrl
// Sequencer: divide, then with valid settings four SHA-256 compressions, truncation and modulo; output.
// ----------------------------------------------------------------------------
module totp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  totp_pkg::status_t st,
  output totp_pkg::cmd_t    cmd
);
  import totp_pkg::*;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]       blk_r, blk_nxt;

  // State and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      blk_r   <= BLK_IPAD;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      blk_r   <= blk_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    blk_nxt   = blk_r;
    cmd       = '0;
    cmd.blk_sel = blk_r;
    cmd.rnd_idx = cnt_r;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        // no transaction is taken while reset is held
        if (rst_n) begin
          in_ready = 1'b1;
          if (in_valid) begin
            cmd.load_in = 1'b1;
            cnt_nxt   = '0;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) begin
          blk_nxt   = BLK_IPAD;
          state_nxt = st.valid ? ST_HLOAD : ST_FINISH;
        end
      end
      ST_HLOAD: begin
        cmd.blk_load = 1'b1;
        cnt_nxt   = '0;
        state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.round = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == RND_LAST) state_nxt = ST_HADD;
      end
      ST_HADD: begin
        cmd.hadd = 1'b1;
        blk_nxt  = blk_r + 1'b1;
        state_nxt = (blk_r == BLK_INNER) ? ST_TRUNC : ST_HLOAD;
      end
      ST_TRUNC: begin
        cmd.trunc_load = 1'b1;
        cnt_nxt   = '0;
        state_nxt = ST_MOD;
      end
      ST_MOD: begin
        cmd.mod_step = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == MOD_LAST) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (!st.out_full) begin
          cmd.out_load = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

[sv/totp_dp.sv]
// ----------------------------------------------------------------------------
// totp_dp
// Datapath: config registers, period divider, SHA-256 round unit, dynamic
// truncation, code modulo divider and the output register.
// ----------------------------------------------------------------------------
module totp_dp #(
  parameter int KEY_BYTES = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [totp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [totp_pkg::CFG_W-1:0]          cfg_data,
  input  logic [totp_pkg::TIME_W-1:0]         in_time,
  input  totp_pkg::cmd_t                      cmd,
  output totp_pkg::status_t                   st,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [totp_pkg::CODE_W-1:0]         out_code,
  output logic [totp_pkg::LEFT_W-1:0]         out_left,
  output logic                                out_code_valid,
  output logic                                out_long
);
  import totp_pkg::*;

  localparam logic [6:0] KB = 7'(KEY_BYTES);

  logic [63:0]       kw_r [4];
  logic [5:0]        klen_r;
  logic [15:0]       per_r;
  logic [3:0]        digs_r;

  logic [6:0]        klen_eff;
  logic [3:0]        digs_sat;
  logic              valid;

  logic [62:0]       q_r;
  logic [15:0]       drem_r;
  logic [16:0]       dsh;
  logic              dge;

  logic [31:0]       h_r [8];
  logic [31:0]       v_r [8];
  logic [31:0]       w_r [16];
  logic [255:0]      inner_r;
  logic [255:0]      digest;
  logic [255:0]      key_m;
  logic [511:0]      blk;

  logic [31:0]       t1, t2, w_new, e, a;

  logic [255:0]      dshift;
  logic [30:0]       word;
  logic [30:0]       mq_r;
  logic [29:0]       mrem_r;
  logic [30:0]       msh;
  logic [29:0]       mdiv;
  logic              mge;

  logic              out_full_r;
  logic [CODE_W-1:0] code_r;
  logic [LEFT_W-1:0] left_r;
  logic              cv_r, long_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) kw_r[i] <= '0;
      klen_r <= '0;
      per_r  <= 16'd30;
      digs_r <= 4'd6;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY0:   kw_r[0] <= cfg_data;
        REG_KEY1:   kw_r[1] <= cfg_data;
        REG_KEY2:   kw_r[2] <= cfg_data;
        REG_KEY3:   kw_r[3] <= cfg_data;
        REG_KLEN:   klen_r  <= cfg_data[5:0];
        REG_PERIOD: per_r   <= cfg_data[15:0];
        REG_DIGITS: digs_r  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Derived settings
  assign klen_eff = ({1'b0, klen_r} > KB) ? KB : {1'b0, klen_r};
  assign digs_sat = (digs_r > 4'd9) ? 4'd9 : digs_r;
  assign valid    = (klen_eff != '0) && (per_r != '0) && (digs_sat != '0);
  assign st.valid    = valid;
  assign st.out_full = out_full_r;

  // Restoring divider: time / period, one quotient bit a cycle
  assign dsh = {drem_r, q_r[62]};
  assign dge = dsh >= {1'b0, per_r};
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      q_r    <= in_time;
      drem_r <= '0;
    end else if (cmd.div_step) begin
      q_r    <= {q_r[61:0], dge};
      drem_r <= dge ? 16'(dsh - {1'b0, per_r}) : dsh[15:0];
    end
  end

  // Masked key, bytes beyond the effective length read as zero
  always_comb begin
    for (int i = 0; i < 32; i++) begin
      key_m[255 - 8*i -: 8] = (7'(i) < klen_eff) ? kw_r[i/8][63 - 8*(i%8) -: 8] : 8'h00;
    end
  end

  // Message block for the current compression
  always_comb begin
    case (cmd.blk_sel)
      BLK_IPAD:  blk = {key_m ^ {32{8'h36}}, {32{8'h36}}};
      BLK_MSG:   blk = {1'b0, q_r, 8'h80, 376'b0, 64'd576};
      BLK_OPAD:  blk = {key_m ^ {32{8'h5c}}, {32{8'h5c}}};
      default:   blk = {inner_r, 8'h80, 184'b0, 64'd768};
    endcase
  end

  // One SHA-256 round
  always_comb begin
    e = v_r[4];
    a = v_r[0];
    t1 = v_r[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & v_r[5]) ^ (~e & v_r[6]))
         + SHA_K[cmd.rnd_idx] + w_r[0];
    t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & v_r[1]) ^ (a & v_r[2]) ^ (v_r[1] & v_r[2]));
    w_new = w_r[0] + (rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3)) + w_r[9]
          + (rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10));
  end

  // Hash state, working variables and message schedule window
  always_ff @(posedge clk) begin
    if (cmd.blk_load) begin
      for (int i = 0; i < 16; i++) w_r[i] <= blk[511 - 32*i -: 32];
      if (cmd.blk_sel == BLK_IPAD || cmd.blk_sel == BLK_OPAD) begin
        for (int i = 0; i < 8; i++) begin
          h_r[i] <= SHA_IV[i];
          v_r[i] <= SHA_IV[i];
        end
      end else begin
        for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
      end
      if (cmd.blk_sel == BLK_OPAD) inner_r <= digest;
    end else if (cmd.round) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= w_new;
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end else if (cmd.hadd) begin
      for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) digest[255 - 32*i -: 32] = h_r[i];
  end

  // Dynamic truncation: 31-bit word at the offset in the last nibble
  assign dshift = digest << {digest[3:0], 3'b000};
  assign word   = dshift[254:224];

  // Restoring divider for word mod 10^digits
  assign mdiv = pow10(digs_sat);
  assign msh  = {mrem_r, mq_r[30]};
  assign mge  = {1'b0, msh} >= {2'b0, mdiv};
  always_ff @(posedge clk) begin
    if (cmd.trunc_load) begin
      mq_r   <= word;
      mrem_r <= '0;
    end else if (cmd.mod_step) begin
      mq_r   <= {mq_r[29:0], 1'b0};
      mrem_r <= mge ? 30'(msh - {1'b0, mdiv}) : msh[29:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_full_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_full_r <= 1'b1;
    end else if (out_ready) begin
      out_full_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      code_r <= valid ? mrem_r : '0;
      left_r <= (per_r != '0) ? 16'(per_r - drem_r) : '0;
      cv_r   <= valid;
      long_r <= klen_eff >= 7'd10;
    end
  end

  assign out_valid      = out_full_r;
  assign out_code       = code_r;
  assign out_left       = left_r;
  assign out_code_valid = cv_r;
  assign out_long       = long_r;

endmodule

[sv/totp_hmac_sha256_code.sv]
// ----------------------------------------------------------------------------
// totp_hmac_sha256_code
// Time-based one-time password (HMAC-SHA256) code generator.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one transaction carries time_seconds. Accepted only while idle.
//   out_ch : one transaction per input: code, seconds_left, code_valid and
//            secret_long_enough, held in an output register until taken.
//   cfg_*  : write key words, key length, period and digits while idle.
// Sequence: accept, then divide one quotient bit per step; with a non-empty key,
//   period and digits, 4 compressions (load, 64 rounds, final add), truncation
//   and one modulo step per dividend bit; then load the output. All four
//   compressions share the single SHA-256 round unit.
// A new time is accepted only after the last result is loaded for output.
// Reset: rst_n low clears control, output valid, and loads register defaults
//   (empty key, period 30, 6 digits).
// Stall: while out_ch is not ready the finished result waits in the output
//   register; the block may take and process the next time, then waits.
// ----------------------------------------------------------------------------
module totp_hmac_sha256_code #(
  parameter int KEY_BYTES = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  totp_in_if.sink                          in_ch,
  totp_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [totp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [totp_pkg::CFG_W-1:0]       cfg_data
);
  import totp_pkg::*;

  cmd_t    cmd;
  status_t st;
  logic    in_ready;

  assign in_ch.ready = in_ready;

  totp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  totp_dp #(.KEY_BYTES(KEY_BYTES)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_time        (in_ch.time_seconds),
    .cmd            (cmd),
    .st             (st),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .out_code       (out_ch.code),
    .out_left       (out_ch.seconds_left),
    .out_code_valid (out_ch.code_valid),
    .out_long       (out_ch.secret_long_enough)
  );

  // Only one transaction is in flight
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ready |=> !in_ready)
    else $error("input accepted while busy");

  // Results are never loaded over an untaken one
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !st.out_full)
    else $error("output register overwritten");

  // A code without valid settings (key, period, digits) is zero
  a_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.code_valid |-> out_ch.code == '0)
    else $error("code not zero when invalid");

endmodule

[tb/totp_hmac_sha256_code_tb.sv]
// ----------------------------------------------------------------------------
// totp_hmac_sha256_code_tb
// Checks the TOTP code block: every returned code, seconds-left value, code_valid and
// key flag is compared with a behavioral HMAC-SHA256 TOTP computation (typed directed rows with
// their typed-in values), over directed corner cases and random times, keys, periods and digit counts.
// ----------------------------------------------------------------------------
module totp_hmac_sha256_code_tb;
  import totp_pkg::*;

  localparam int N_RANDOM = 640;

  // Result fields of one transaction
  typedef struct {
    logic [CODE_W-1:0] code;
    logic [LEFT_W-1:0] left;
    logic              cvalid;
    logic              long_key;
  } totp_res_t;

  // Directed rows: register setup plus time; expected fields when typed in
  typedef struct {
    logic [5:0]        klen;
    logic [15:0]       period;
    logic [3:0]        digits;
    logic [TIME_W-1:0] tsec;
    bit                typed;
    totp_res_t         res;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  totp_in_if  in_ch ();
  totp_out_if out_ch ();

  totp_hmac_sha256_code dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Local copy of the register file
  logic [63:0] key_words [4];
  logic [5:0]  key_len;
  logic [15:0] period_s;
  logic [3:0]  code_digs;

  totp_res_t pending_codes[$];
  int n_errors;
  int n_checked;
  int n_sent;
  bit hold_off;
  bit drain_done;

  // Clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mismatch report
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch on %s: got %0d, want %0d (result %0d)", what, got, want,
             n_checked);
    n_errors++;
  endtask

  // ---- SHA-256 ----
  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void sha_compress(ref logic [31:0] h[8],
                                       input logic [7:0] blk[64]);
    logic [31:0] w[64];
    logic [31:0] v[8];
    logic [31:0] t1, t2, s0, s1;
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (int i = 16; i < 64; i++) begin
      s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    for (int i = 0; i < 8; i++) v[i] = h[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25)) +
           ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[i] + w[i];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22)) +
           ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) h[i] += v[i];
  endfunction

  // Hash of a 64-byte pad block followed by a short tail
  function automatic void sha_pad_tail(input logic [7:0] pad[64],
                                       input logic [7:0] tail[32], input int len,
                                       output logic [7:0] dig[32]);
    logic [31:0] h[8];
    logic [7:0] blk[64];
    logic [15:0] bits;
    bits = 16'((64 + len) * 8);
    for (int i = 0; i < 8; i++) h[i] = SHA_IV[i];
    sha_compress(h, pad);
    for (int i = 0; i < 64; i++) blk[i] = (i < len) ? tail[i] : 8'h00;
    blk[len] = 8'h80;
    blk[62] = bits[15:8];
    blk[63] = bits[7:0];
    sha_compress(h, blk);
    for (int i = 0; i < 8; i++)
      {dig[4*i], dig[4*i+1], dig[4*i+2], dig[4*i+3]} = h[i];
  endfunction

  // TOTP result for one time under the current registers
  function automatic totp_res_t totp_predict(input logic [TIME_W-1:0] tsec);
    totp_res_t r;
    int klen, digs, off;
    logic [7:0] ipad[64], opad[64], tail[32], inner[32], mac[32], kb;
    logic [63:0] counter, divisor;
    logic [31:0] word;
    klen = (key_len > 32) ? 32 : key_len;
    digs = (code_digs > 9) ? 9 : code_digs;
    r.cvalid = (klen != 0) && (period_s != 0) && (digs != 0);
    r.long_key = klen >= 10;
    r.left = (period_s != 0) ? 16'(period_s - (64'(tsec) % period_s)) : '0;
    r.code = '0;
    if (r.cvalid) begin
      counter = 64'(tsec) / period_s;
      for (int i = 0; i < 64; i++) begin
        kb = (i < klen) ? key_words[i/8][63-8*(i%8) -: 8] : 8'h00;
        ipad[i] = kb ^ 8'h36;
        opad[i] = kb ^ 8'h5c;
      end
      for (int i = 0; i < 32; i++) tail[i] = (i < 8) ? counter[63-8*i -: 8] : 8'h00;
      sha_pad_tail(ipad, tail, 8, inner);
      sha_pad_tail(opad, inner, 32, mac);
      off = mac[31][3:0];
      word = {mac[off] & 8'h7f, mac[off+1], mac[off+2], mac[off+3]};
      divisor = 1;
      for (int i = 0; i < digs; i++) divisor *= 10;
      r.code = CODE_W'(64'(word) % divisor);
    end
    return r;
  endfunction

  // ---- Configuration ----
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: key_words[idx[1:0]] = val;
      REG_KLEN:   key_len = val[5:0];
      REG_PERIOD: period_s = val[15:0];
      REG_DIGITS: code_digs = val[3:0];
      default: ;
    endcase
  endtask

  task automatic write_setup(input logic [5:0] kl, input logic [15:0] per,
                             input logic [3:0] dg);
    write_reg(REG_KLEN, 64'(kl));
    write_reg(REG_PERIOD, 64'(per));
    write_reg(REG_DIGITS, 64'(dg));
  endtask

  // Wait until all results are back, then let the block settle
  task automatic wait_drained();
    wait (pending_codes.size() == 0);
    repeat (400) @(negedge clk);
  endtask

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 93) return $urandom_range(1, 4);
    return $urandom_range(20, 900);
  endfunction

  // Offer one time; record the expectation at acceptance
  task automatic send_time(input logic [TIME_W-1:0] tsec, input bit typed,
                           input totp_res_t typed_res);
    totp_res_t p;
    in_ch.valid = 1'b1;
    in_ch.time_seconds = tsec;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    p = totp_predict(tsec);
    if (typed) begin
      if (typed_res.code != p.code || typed_res.left != p.left ||
          typed_res.cvalid != p.cvalid || typed_res.long_key != p.long_key)
        $display("note: typed row %0d differs from predictor", n_sent);
      p = typed_res;
    end
    pending_codes.push_back(p);
    n_sent++;
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  function automatic logic [TIME_W-1:0] rand_time();
    logic [TIME_W-1:0] t;
    case ($urandom_range(0, 3))
      0: t = TIME_W'($urandom_range(0, 2000));
      1: t = TIME_W'({$urandom, $urandom});
      2: t = TIME_W'(64'($urandom) + 64'd1700000000);
      default: t = {TIME_W{1'b1}} - TIME_W'($urandom_range(0, 100));
    endcase
    return t;
  endfunction

  // ---- Stimulus ----
  dir_row_t dir_rows[$];
  totp_res_t nores;

  initial begin
    logic [5:0] kl;
    logic [15:0] per;
    logic [3:0] dg;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.time_seconds = '0;
    n_errors = 0;
    n_checked = 0;
    n_sent = 0;
    hold_off = 1'b0;
    drain_done = 1'b0;
    nores = '{default: '0};
    for (int i = 0; i < 4; i++) key_words[i] = '0;
    key_len = 0;
    period_s = 30;
    code_digs = 6;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed rows: reset state, empty key, zero period, digit extremes, key length and period extremes
    dir_rows = '{
      '{6'd0, 16'd30, 4'd6, 63'd59, 1'b1, '{30'd0, 16'd1, 1'b0, 1'b0}},
      '{6'd0, 16'd30, 4'd6, 63'd0, 1'b1, '{30'd0, 16'd30, 1'b0, 1'b0}},
      '{6'd20, 16'd0, 4'd6, 63'd1234, 1'b1, '{30'd0, 16'd0, 1'b0, 1'b1}},
      '{6'd20, 16'd30, 4'd0, 63'd61, 1'b1, '{30'd0, 16'd29, 1'b0, 1'b1}},
      '{6'd20, 16'd30, 4'd6, 63'd59, 1'b0, nores},
      '{6'd20, 16'd30, 4'd8, 63'd1111111109, 1'b0, nores},
      '{6'd20, 16'd30, 4'd9, 63'd2000000000, 1'b0, nores},
      '{6'd20, 16'd30, 4'd15, 63'd20000000000, 1'b0, nores},
      '{6'd20, 16'd30, 4'd1, 63'd0, 1'b0, nores},
      '{6'd1, 16'd1, 4'd6, {TIME_W{1'b1}}, 1'b0, nores},
      '{6'd9, 16'd65535, 4'd6, {TIME_W{1'b1}}, 1'b0, nores},
      '{6'd10, 16'd65535, 4'd7, 63'd65535, 1'b0, nores},
      '{6'd32, 16'd60, 4'd6, 63'd1700000000, 1'b0, nores},
      '{6'd33, 16'd30, 4'd6, 63'd1700000000, 1'b0, nores},
      '{6'd63, 16'd30, 4'd6, {1'b1, 62'd0}, 1'b0, nores}
    };
    write_reg(REG_KEY0, 64'h3132333435363738);
    write_reg(REG_KEY1, 64'h3930313233343536);
    write_reg(REG_KEY2, 64'h3738393031323334);
    write_reg(REG_KEY3, 64'hffffffffffffffff);
    // reset-state rows use the default registers
    key_len = 0;
    foreach (dir_rows[i]) begin
      if (i >= 2 || dir_rows[i].klen != key_len ||
          dir_rows[i].period != period_s || dir_rows[i].digits != code_digs) begin
        wait_drained();
        write_setup(dir_rows[i].klen, dir_rows[i].period, dir_rows[i].digits);
      end
      send_time(dir_rows[i].tsec, dir_rows[i].typed, dir_rows[i].res);
    end
    // unknown register index must be ignored
    wait_drained();
    write_reg(3'd7, 64'hffffffffffffffff);
    send_time(63'd1700000000, 1'b0, nores);

    // Random phases with fresh settings
    for (int ph = 0; ph < 16; ph++) begin
      wait_drained();
      for (int k = 0; k < 4; k++)
        write_reg(CFG_IDX_W'(k), (ph % 5 == 0) ? 64'(0) : {$urandom, $urandom});
      kl = (ph % 4 == 1) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(1, 32));
      per = (ph % 7 == 3) ? 16'($urandom_range(0, 1)) :
            (ph % 7 == 5) ? 16'hffff : 16'($urandom_range(1, 120));
      dg = (ph % 8 == 6) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 9));
      write_setup(kl, per, dg);
      if (ph == 4) begin
        // receiver holds off while the sender keeps offering
        hold_off = 1'b1;
        for (int i = 0; i < 4; i++) send_time(rand_time(), 1'b0, nores);
      end
      for (int i = 0; i < N_RANDOM / 16; i++) begin
        repeat (gap_len()) @(negedge clk);
        send_time(rand_time(), 1'b0, nores);
      end
    end
    wait (pending_codes.size() == 0);
    repeat (400) @(negedge clk);
    drain_done = 1'b1;
  end

  // Receiver: random stalls, plus one long hold-off
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_ch.ready <= 1'b0;
        repeat (2000) @(negedge clk);
        hold_off = 1'b0;
      end
      if ($urandom_range(0, 60) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(20, 600)) @(negedge clk);
      end else begin
        out_ch.ready <= ($urandom_range(0, 3) != 0) ? 1'b1 : 1'b0;
      end
    end
  end

  // Result checker
  always @(posedge clk) begin
    totp_res_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_codes.size() == 0) begin
        report_mismatch("result count", 64'(n_checked + 1), 64'(n_sent));
      end else begin
        e = pending_codes.pop_front();
        if (out_ch.code !== e.code) report_mismatch("code", 64'(out_ch.code), 64'(e.code));
        if (out_ch.seconds_left !== e.left)
          report_mismatch("seconds_left", 64'(out_ch.seconds_left), 64'(e.left));
        if (out_ch.code_valid !== e.cvalid)
          report_mismatch("code_valid", 64'(out_ch.code_valid), 64'(e.cvalid));
        if (out_ch.secret_long_enough !== e.long_key)
          report_mismatch("secret_long_enough", 64'(out_ch.secret_long_enough),
                          64'(e.long_key));
        n_checked++;
      end
    end
  end

  // End of run
  initial begin
    wait (drain_done);
    $display("checked %0d code results for %0d times over 16 random register setups",
             n_checked, n_sent);
    $display("plus directed key, period and digit corner cases");
    if (n_errors == 0 && pending_codes.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #100000000;
    $display("timeout with %0d results outstanding", pending_codes.size());
    $display("TB_ERROR");
    $finish;
  end

endmodule
